@@ design/sparse_ell_matrix_vector_multiply_core_macros.svh @@
// Assertion macros for the sparse ELLPACK matrix-vector core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SPARSE_ELL_MATRIX_VECTOR_MULTIPLY_CORE_MACROS_SVH
`define SPARSE_ELL_MATRIX_VECTOR_MULTIPLY_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SEMV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SEMV_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SEMV_ASSERT(lbl, clk, rst_n, prop, msg)
`define SEMV_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ design/semv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the sparse ELLPACK matrix-vector core.
// Used by semv_ctrl, semv_datapath and the top level; depends on nothing.
package semv_pkg;

  localparam int VEC_DEPTH_DEF     = 1024;
  localparam int MAX_ROW_WIDTH_DEF = 64;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int COL_W   = 11;
  localparam int SUM_W   = 48;
  localparam int ROW_W   = 16;
  localparam int RW_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_MATRIX = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_PAD,
    ST_EMIT
  } ctl_state_t;

  // Product sequence of one matrix entry; real mode stops after STEP_II.
  typedef enum logic [2:0] {
    STEP_RR,
    STEP_II,
    STEP_RI,
    STEP_IR,
    STEP_FOLD
  } mul_step_t;

  typedef enum logic [1:0] {
    MUL_RR,
    MUL_II,
    MUL_RI,
    MUL_IR
  } mul_sel_t;

  typedef enum logic [2:0] {
    TERM_NONE,
    TERM_LOAD_RE,
    TERM_SUB_RE,
    TERM_LOAD_IM,
    TERM_ADD_IM
  } term_op_t;

  typedef struct packed {
    logic     take;
    logic     mul_en;
    mul_sel_t mul_sel;
    term_op_t term_op;
    logic     acc_en;
    logic     count_en;
    logic     emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic item_load;
    logic item_pad;
    logic complex_mode;
    logic row_end;
    logic out_free;
  } dp_sts_t;

endpackage

@@ design/semv_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the sparse ELLPACK matrix-vector core: sequences accept,
// product steps, accumulate and result hand-off. Depends on semv_pkg.
module semv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  semv_pkg::dp_sts_t  sts,
  output semv_pkg::ctl_cmd_t cmd
);

  semv_pkg::ctl_state_t state_r, state_nxt;
  semv_pkg::mul_step_t  step_r, step_nxt;
  semv_pkg::mul_step_t  last_step;

  assign last_step = sts.complex_mode ? semv_pkg::STEP_FOLD : semv_pkg::STEP_II;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= semv_pkg::ST_IDLE;
      step_r  <= semv_pkg::STEP_RR;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      semv_pkg::ST_IDLE: begin
        step_nxt = semv_pkg::STEP_RR;
        if (in_valid && !sts.item_load) begin
          state_nxt = sts.item_pad ? semv_pkg::ST_PAD : semv_pkg::ST_MUL;
        end
      end
      semv_pkg::ST_MUL: begin
        if (step_r == last_step) begin
          state_nxt = semv_pkg::ST_SUM;
          step_nxt  = semv_pkg::STEP_RR;
        end else begin
          step_nxt = semv_pkg::mul_step_t'(step_r + 3'd1);
        end
      end
      semv_pkg::ST_SUM, semv_pkg::ST_PAD: begin
        state_nxt = sts.row_end ? semv_pkg::ST_EMIT : semv_pkg::ST_IDLE;
      end
      semv_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = semv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = semv_pkg::ST_IDLE;
        step_nxt  = semv_pkg::STEP_RR;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.take     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.mul_sel  = semv_pkg::MUL_RR;
    cmd.term_op  = semv_pkg::TERM_NONE;
    cmd.acc_en   = 1'b0;
    cmd.count_en = 1'b0;
    cmd.emit     = 1'b0;
    case (state_r)
      semv_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      semv_pkg::ST_MUL: begin
        // Past RR each step folds the last product; FOLD, real II form none.
        case (step_r)
          semv_pkg::STEP_RR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = semv_pkg::MUL_RR;
          end
          semv_pkg::STEP_II: begin
            cmd.mul_en  = sts.complex_mode;
            cmd.mul_sel = semv_pkg::MUL_II;
            cmd.term_op = semv_pkg::TERM_LOAD_RE;
          end
          semv_pkg::STEP_RI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = semv_pkg::MUL_RI;
            cmd.term_op = semv_pkg::TERM_SUB_RE;
          end
          semv_pkg::STEP_IR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = semv_pkg::MUL_IR;
            cmd.term_op = semv_pkg::TERM_LOAD_IM;
          end
          semv_pkg::STEP_FOLD: begin
            cmd.term_op = semv_pkg::TERM_ADD_IM;
          end
          default: begin
            cmd.term_op = semv_pkg::TERM_NONE;
          end
        endcase
      end
      semv_pkg::ST_SUM: begin
        cmd.acc_en   = 1'b1;
        cmd.count_en = 1'b1;
      end
      semv_pkg::ST_PAD: begin
        cmd.count_en = 1'b1;
      end
      semv_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ design/semv_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the sparse ELLPACK matrix-vector core: vector store, shared
// multiplier, term and accumulator registers, counters, config and output
// registers. Depends on semv_pkg and the core macros header.
`include "sparse_ell_matrix_vector_multiply_core_macros.svh"
module semv_datapath #(
  parameter int VEC_DEPTH     = semv_pkg::VEC_DEPTH_DEF,
  parameter int MAX_ROW_WIDTH = semv_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_cmd,
  input  logic        [semv_pkg::IDX_W-1:0]      in_vec_index,
  input  logic signed [semv_pkg::VAL_W-1:0]      in_val_re,
  input  logic signed [semv_pkg::VAL_W-1:0]      in_val_im,
  input  logic signed [semv_pkg::COL_W-1:0]      in_col,
  input  logic                                   cfg_valid,
  input  logic        [semv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [semv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  semv_pkg::ctl_cmd_t                     cmd,
  output semv_pkg::dp_sts_t                      sts,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [semv_pkg::SUM_W-1:0]      out_sum_re,
  output logic signed [semv_pkg::SUM_W-1:0]      out_sum_im,
  output logic        [semv_pkg::ROW_W-1:0]      out_row_index,
  output logic                                   out_last_row
);

  localparam int AW  = $clog2(VEC_DEPTH);
  localparam int CW  = $clog2(MAX_ROW_WIDTH + 1);
  localparam int WW  = (CW > semv_pkg::RW_W) ? CW : semv_pkg::RW_W;
  localparam int VW  = semv_pkg::VAL_W;
  localparam int SW  = semv_pkg::SUM_W;
  localparam int TW  = SW + 1;
  localparam int XW  = SW + 2;
  localparam int RCW = 20;
  localparam int QDW = 27;
  localparam int RECIP = (1 << RCW) / VEC_DEPTH;

  localparam logic signed [XW-1:0] ACC_MAX = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] ACC_MIN = -ACC_MAX - XW'(1);

  // Store index modulo depth: reciprocal multiply, then one correction.
  function automatic logic [AW-1:0] fold_index(input logic [semv_pkg::IDX_W-1:0] x);
    logic [semv_pkg::IDX_W+RCW-1:0] prod;
    logic [semv_pkg::IDX_W-1:0]     q;
    logic [QDW-1:0]                 qd;
    logic [QDW-1:0]                 r;
    prod = (semv_pkg::IDX_W+RCW)'(x) * (semv_pkg::IDX_W+RCW)'(RECIP);
    q    = prod[semv_pkg::IDX_W+RCW-1:RCW];
    qd   = QDW'(q) * QDW'(VEC_DEPTH);
    r    = QDW'(x) - qd;
    if (r >= QDW'(VEC_DEPTH)) begin
      r = r - QDW'(VEC_DEPTH);
    end
    return AW'(r);
  endfunction

  function automatic logic signed [SW-1:0] sat_acc(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] c;
    c = v;
    if (v > ACC_MAX) begin
      c = ACC_MAX;
    end else if (v < ACC_MIN) begin
      c = ACC_MIN;
    end
    return c[SW-1:0];
  endfunction

  // Configuration
  logic                          complex_mode_r;
  logic [semv_pkg::RW_W-1:0]     row_width_r;
  logic [semv_pkg::ROW_W-1:0]    row_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complex_mode_r <= 1'b0;
      row_width_r    <= semv_pkg::RW_W'(1);
      row_count_r    <= semv_pkg::ROW_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        semv_pkg::CFG_COMPLEX_MODE: complex_mode_r <= cfg_data[0];
        semv_pkg::CFG_ROW_WIDTH:    row_width_r    <= cfg_data[semv_pkg::RW_W-1:0];
        semv_pkg::CFG_ROW_COUNT:    row_count_r    <= cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Vector store, {im, re} per word, registered read
  logic [2*VW-1:0]         mem [VEC_DEPTH];
  logic [2*VW-1:0]         rd_r;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;

  assign wr_addr = fold_index(in_vec_index);
  assign rd_addr = fold_index(in_col[semv_pkg::IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.take && in_cmd == semv_pkg::CMD_LOAD) begin
      mem[wr_addr] <= {in_val_im, in_val_re};
    end
    if (cmd.take && in_cmd == semv_pkg::CMD_MATRIX) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Matrix value of the transaction in flight
  logic signed [VW-1:0] mat_re_r, mat_im_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mat_re_r <= in_val_re;
      mat_im_r <= in_val_im;
    end
  end

  // Shared multiplier, floored to Q32.16 on the way into the terms
  logic signed [VW-1:0]   mul_a, mul_b;
  logic signed [2*VW-1:0] prod_r;
  logic signed [SW-1:0]   prod_fl;
  logic signed [VW-1:0]   vec_re, vec_im;

  assign vec_re  = rd_r[VW-1:0];
  assign vec_im  = rd_r[2*VW-1:VW];
  assign prod_fl = prod_r[2*VW-1:2*VW-SW];

  always_comb begin
    case (cmd.mul_sel)
      semv_pkg::MUL_RR: begin mul_a = mat_re_r; mul_b = vec_re; end
      semv_pkg::MUL_II: begin mul_a = mat_im_r; mul_b = vec_im; end
      semv_pkg::MUL_RI: begin mul_a = mat_re_r; mul_b = vec_im; end
      semv_pkg::MUL_IR: begin mul_a = mat_im_r; mul_b = vec_re; end
      default:          begin mul_a = mat_re_r; mul_b = vec_re; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= (2*VW)'(mul_a) * (2*VW)'(mul_b);
    end
  end

  logic signed [TW-1:0] term_re_r, term_im_r;

  always_ff @(posedge clk) begin
    case (cmd.term_op)
      semv_pkg::TERM_LOAD_RE: term_re_r <= TW'(prod_fl);
      semv_pkg::TERM_SUB_RE:  term_re_r <= term_re_r - TW'(prod_fl);
      semv_pkg::TERM_LOAD_IM: term_im_r <= TW'(prod_fl);
      semv_pkg::TERM_ADD_IM:  term_im_r <= term_im_r + TW'(prod_fl);
      default: begin
        // hold
      end
    endcase
  end

  // Accumulators and counters
  logic signed [SW-1:0]       acc_re_r, acc_im_r;
  logic [CW-1:0]              entry_count_r;
  logic [semv_pkg::ROW_W-1:0] row_counter_r;
  logic signed [XW-1:0]       sum_re, sum_im;
  logic [WW-1:0]              eff_width, entry_inc;
  logic [semv_pkg::ROW_W:0]   row_inc, eff_count;
  logic                       last_row;

  assign sum_re = XW'(acc_re_r) + XW'(term_re_r);
  assign sum_im = XW'(acc_im_r) + XW'(term_im_r);

  always_comb begin
    eff_width = WW'(row_width_r);
    if (eff_width == '0) begin
      eff_width = WW'(1);
    end else if (eff_width > WW'(MAX_ROW_WIDTH)) begin
      eff_width = WW'(MAX_ROW_WIDTH);
    end
  end

  assign entry_inc = WW'(entry_count_r) + WW'(1);
  assign row_inc   = {1'b0, row_counter_r} + (semv_pkg::ROW_W+1)'(1);
  assign eff_count = (row_count_r == '0) ? (semv_pkg::ROW_W+1)'(1) : {1'b0, row_count_r};
  assign last_row  = row_inc >= eff_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r      <= '0;
      acc_im_r      <= '0;
      entry_count_r <= '0;
      row_counter_r <= '0;
    end else if (cmd.emit) begin
      acc_re_r      <= '0;
      acc_im_r      <= '0;
      entry_count_r <= '0;
      row_counter_r <= last_row ? '0 : row_inc[semv_pkg::ROW_W-1:0];
    end else begin
      if (cmd.acc_en) begin
        acc_re_r <= sat_acc(sum_re);
        if (complex_mode_r) begin
          acc_im_r <= sat_acc(sum_im);
        end
      end
      if (cmd.count_en) begin
        entry_count_r <= entry_inc[CW-1:0];
      end
    end
  end

  // Output register
  logic                       out_valid_r;
  logic signed [SW-1:0]       out_sum_re_r, out_sum_im_r;
  logic [semv_pkg::ROW_W-1:0] out_row_index_r;
  logic                       out_last_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sum_re_r    <= acc_re_r;
      out_sum_im_r    <= complex_mode_r ? acc_im_r : '0;
      out_row_index_r <= row_counter_r;
      out_last_row_r  <= last_row;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sum_re    = out_sum_re_r;
  assign out_sum_im    = out_sum_im_r;
  assign out_row_index = out_row_index_r;
  assign out_last_row  = out_last_row_r;

  assign sts.item_load    = (in_cmd == semv_pkg::CMD_LOAD);
  assign sts.item_pad     = in_col[semv_pkg::COL_W-1];
  assign sts.complex_mode = complex_mode_r;
  assign sts.row_end      = entry_inc >= eff_width;
  assign sts.out_free     = !out_valid_r || !out_stall;

  `SEMV_ASSERT(a_emit_slot_free, clk, rst_n, !cmd.emit || !out_valid_r || !out_stall, "result loaded over a pending result")
  `SEMV_ASSERT(a_entry_in_range, clk, rst_n, entry_count_r <= CW'(MAX_ROW_WIDTH), "entry count beyond row width limit")
  `SEMV_ASSERT_NEXT(a_real_im_zero, clk, rst_n, cmd.emit && !complex_mode_r, out_sum_im == '0, "imaginary sum not zero in real mode")
  `SEMV_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid, "emitted result not presented")

endmodule

@@ design/sparse_ell_matrix_vector_multiply_core.sv @@
`timescale 1ns / 1ps
// ELLPACK sparse matrix times dense vector, real or complex, Q16.16 in and
// saturated Q32.16 out. One transaction is worked at a time through a single
// shared 32x32 multiplier stepped by the controller: a load item is only
// accepted, a padding entry is accepted and counted, a real entry is accepted,
// taken through two product steps and accumulated, and a complex entry likewise
// with five product steps. The entry that closes a row then enters a hand-off
// state that passes its result to the output register, waiting while a previous
// result is still held. The vector store needs no clearing pass; read only
// entries that were loaded. Depends on semv_pkg, semv_ctrl and semv_datapath.
module sparse_ell_matrix_vector_multiply_core #(
  parameter int VEC_DEPTH     = semv_pkg::VEC_DEPTH_DEF,
  parameter int MAX_ROW_WIDTH = semv_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_cmd,
  input  logic        [semv_pkg::IDX_W-1:0]      in_vec_index,
  input  logic signed [semv_pkg::VAL_W-1:0]      in_val_re,
  input  logic signed [semv_pkg::VAL_W-1:0]      in_val_im,
  input  logic signed [semv_pkg::COL_W-1:0]      in_col,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [semv_pkg::SUM_W-1:0]      out_sum_re,
  output logic signed [semv_pkg::SUM_W-1:0]      out_sum_im,
  output logic        [semv_pkg::ROW_W-1:0]      out_row_index,
  output logic                                   out_last_row,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [semv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [semv_pkg::CFG_DATA_W-1:0] cfg_data
);

  semv_pkg::ctl_cmd_t cmd;
  semv_pkg::dp_sts_t  sts;

  // Register writes are always accepted; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  semv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  semv_datapath #(
    .VEC_DEPTH     (VEC_DEPTH),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_cmd),
    .in_vec_index  (in_vec_index),
    .in_val_re     (in_val_re),
    .in_val_im     (in_val_im),
    .in_col        (in_col),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sum_re    (out_sum_re),
    .out_sum_im    (out_sum_im),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row)
  );

endmodule

@@ tb/spmv_row_checker.sv @@
`timescale 1ns / 1ps
// Row-result checker for the ELLPACK matrix-vector core: watches the three channels,
// keeps its own vector store, accumulators and registers, and compares every row result.
// Depends on semv_pkg only.
module spmv_row_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic                                   in_cmd,
  input  logic        [semv_pkg::IDX_W-1:0]      in_vec_index,
  input  logic signed [semv_pkg::VAL_W-1:0]      in_val_re,
  input  logic signed [semv_pkg::VAL_W-1:0]      in_val_im,
  input  logic signed [semv_pkg::COL_W-1:0]      in_col,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [semv_pkg::SUM_W-1:0]      out_sum_re,
  input  logic signed [semv_pkg::SUM_W-1:0]      out_sum_im,
  input  logic        [semv_pkg::ROW_W-1:0]      out_row_index,
  input  logic                                   out_last_row,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic        [semv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [semv_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                            rows_pending,
  output int unsigned                            mismatches
);
  import semv_pkg::*;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic        [ROW_W-1:0] row_index;
    logic                    last_row;
  } row_result_t;

  logic signed [VAL_W-1:0] vec_re [VEC_DEPTH_DEF];
  logic signed [VAL_W-1:0] vec_im [VEC_DEPTH_DEF];
  longint                  acc_re;
  longint                  acc_im;
  int unsigned             entries_seen;
  int unsigned             row_ctr;
  logic                    complex_on;
  logic [RW_W-1:0]         width_reg;
  logic [ROW_W-1:0]        count_reg;
  row_result_t             expected_rows [$];
  int unsigned             bad_count = 0;

  // Exact 64-bit product, floored to Q32.16.
  function automatic longint q16_mul(input logic signed [VAL_W-1:0] a,
                                     input logic signed [VAL_W-1:0] b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return prod >>> 16;
  endfunction

  function automatic longint clamp_acc(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  task automatic absorb_entry(input logic signed [VAL_W-1:0] re,
                              input logic signed [VAL_W-1:0] im,
                              input logic signed [COL_W-1:0] col);
    int unsigned addr;
    int unsigned eff_width;
    int unsigned eff_count;
    bit          last;
    row_result_t res;
    // any negative column is padding
    if (!col[COL_W-1]) begin
      addr = col[IDX_W-1:0];
      if (complex_on) begin
        acc_re = clamp_acc(acc_re + q16_mul(re, vec_re[addr]) - q16_mul(im, vec_im[addr]));
        acc_im = clamp_acc(acc_im + q16_mul(re, vec_im[addr]) + q16_mul(im, vec_re[addr]));
      end else begin
        acc_re = clamp_acc(acc_re + q16_mul(re, vec_re[addr]));
      end
    end
    if (width_reg == 0) eff_width = 1;
    else if (width_reg > MAX_ROW_WIDTH_DEF) eff_width = MAX_ROW_WIDTH_DEF;
    else eff_width = width_reg;
    entries_seen++;
    if (entries_seen >= eff_width) begin
      eff_count     = (count_reg == 0) ? 1 : count_reg;
      last          = (row_ctr + 1) >= eff_count;
      res.sum_re    = acc_re[SUM_W-1:0];
      res.sum_im    = complex_on ? acc_im[SUM_W-1:0] : '0;
      res.row_index = row_ctr[ROW_W-1:0];
      res.last_row  = last;
      expected_rows.push_back(res);
      acc_re       = 0;
      acc_im       = 0;
      entries_seen = 0;
      row_ctr      = last ? 0 : ((row_ctr + 1) & 32'h0000_FFFF);
    end
  endtask

  task automatic check_row(input logic signed [SUM_W-1:0] got_re,
                           input logic signed [SUM_W-1:0] got_im,
                           input logic        [ROW_W-1:0] got_row,
                           input logic                    got_last);
    row_result_t want;
    if (expected_rows.size() == 0) begin
      bad_count++;
      if (bad_count <= REPORT_LIMIT)
        $display("unexpected row result: re %0d im %0d row %0d last %0b",
                 got_re, got_im, got_row, got_last);
      return;
    end
    want = expected_rows.pop_front();
    if (got_re !== want.sum_re || got_im !== want.sum_im ||
        got_row !== want.row_index || got_last !== want.last_row) begin
      bad_count++;
      if (bad_count <= REPORT_LIMIT)
        $display("row mismatch: expected re %0d im %0d row %0d last %0b, got re %0d im %0d row %0d last %0b",
                 $signed(want.sum_re), $signed(want.sum_im), want.row_index, want.last_row,
                 got_re, got_im, got_row, got_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      acc_re       = 0;
      acc_im       = 0;
      entries_seen = 0;
      row_ctr      = 0;
      complex_on   = 1'b0;
      width_reg    = 7'd1;
      count_reg    = 16'd1;
      bad_count    = 0;
      expected_rows.delete();
    end else begin
      // results first: an item taken at this edge cannot produce one here
      if (out_valid && !out_stall)
        check_row(out_sum_re, out_sum_im, out_row_index, out_last_row);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COMPLEX_MODE: complex_on = cfg_data[0];
          CFG_ROW_WIDTH:    width_reg  = cfg_data[RW_W-1:0];
          CFG_ROW_COUNT:    count_reg  = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_LOAD) begin
          vec_re[in_vec_index] = in_val_re;
          vec_im[in_vec_index] = in_val_im;
        end else begin
          absorb_entry(in_val_re, in_val_im, in_col);
        end
      end
    end
    rows_pending <= expected_rows.size();
    mismatches   <= bad_count;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the ELLPACK matrix-vector core: clock, reset, register writes,
// directed and random stimulus, receiver stalls and the verdict.
// Depends on semv_pkg, sparse_ell_matrix_vector_multiply_core and spmv_row_checker.
module tb;
  import semv_pkg::*;

  localparam int          RESET_CYCLES   = 2;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          RANDOM_ITEMS   = 500;
  localparam int          CALM_FIRST     = 200;
  localparam int          CALM_LAST      = 300;
  localparam int          SQUEEZE_AT     = 400;
  localparam int          HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  localparam logic [CFG_IDX_W-1:0]    CFG_UNMAPPED = 2'd3;
  localparam logic signed [VAL_W-1:0] Q_MAX        = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN        = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] Q_ONE        = 32'sh0001_0000;
  localparam logic signed [COL_W-1:0] COL_PAD      = -11'sd1;

  logic                    clk;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_cmd       = 1'b0;
  logic [IDX_W-1:0]        in_vec_index = '0;
  logic signed [VAL_W-1:0] in_val_re    = '0;
  logic signed [VAL_W-1:0] in_val_im    = '0;
  logic signed [COL_W-1:0] in_col       = '0;
  logic                    out_stall    = 1'b0;
  logic                    cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index    = '0;
  logic [CFG_DATA_W-1:0]   cfg_data     = '0;

  logic                    in_stall;
  logic                    out_valid;
  logic signed [SUM_W-1:0] out_sum_re;
  logic signed [SUM_W-1:0] out_sum_im;
  logic [ROW_W-1:0]        out_row_index;
  logic                    out_last_row;
  logic                    cfg_ready;

  int unsigned rows_pending;
  int unsigned mismatches;

  bit          calm        = 1'b0;
  logic        squeeze_req = 1'b0;
  int unsigned items_sent  = 0;
  bit          loaded [VEC_DEPTH_DEF];
  int          loaded_list [$];

  sparse_ell_matrix_vector_multiply_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_vec_index (in_vec_index),
    .in_val_re    (in_val_re),
    .in_val_im    (in_val_im),
    .in_col       (in_col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sum_re   (out_sum_re),
    .out_sum_im   (out_sum_im),
    .out_row_index(out_row_index),
    .out_last_row (out_last_row),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  spmv_row_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_vec_index (in_vec_index),
    .in_val_re    (in_val_re),
    .in_val_im    (in_val_im),
    .in_col       (in_col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sum_re   (out_sum_re),
    .out_sum_im   (out_sum_im),
    .out_row_index(out_row_index),
    .out_last_row (out_last_row),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rows_pending (rows_pending),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3, 4: return VAL_W'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic                    cmd,
                           input logic [IDX_W-1:0]        idx,
                           input logic signed [VAL_W-1:0] re,
                           input logic signed [VAL_W-1:0] im,
                           input logic signed [COL_W-1:0] col);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_vec_index <= idx;
    in_val_re    <= re;
    in_val_im    <= im;
    in_col       <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    calm <= (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
    if (items_sent == SQUEEZE_AT) squeeze_req <= 1'b1;
  endtask

  task automatic load_vec(input logic [IDX_W-1:0]        idx,
                          input logic signed [VAL_W-1:0] re,
                          input logic signed [VAL_W-1:0] im);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    send_item(CMD_LOAD, idx, re, im, COL_W'($urandom));
  endtask

  task automatic send_entry(input logic signed [VAL_W-1:0] re,
                            input logic signed [VAL_W-1:0] im,
                            input logic signed [COL_W-1:0] col);
    send_item(CMD_MATRIX, IDX_W'($urandom), re, im, col);
  endtask

  task automatic random_load();
    load_vec(IDX_W'($urandom_range(0, VEC_DEPTH_DEF - 1)), rand_value(), rand_value());
  endtask

  // Columns point only at loaded vector entries, or are padding.
  task automatic random_entry();
    logic signed [COL_W-1:0] col;
    if ($urandom_range(0, 99) < 12)
      col = -COL_W'($urandom_range(1, 1024));
    else
      col = COL_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    send_entry(rand_value(), rand_value(), col);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, drain every expected row, then let the last entry finish.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    bit squeeze_done;
    squeeze_done = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        // hold off long enough for the core to back up into its input
        squeeze_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 38);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [RW_W-1:0]  width_sel;
    logic [ROW_W-1:0] count_sel;
    int unsigned      width_eff;
    int unsigned      rows;
    int unsigned      random_start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Real mode: saturate up, saturate down, padding and a load inside a row.
    write_reg(CFG_COMPLEX_MODE, 16'd0);
    write_reg(CFG_ROW_WIDTH, 16'd4);
    write_reg(CFG_ROW_COUNT, 16'd2);
    load_vec(10'd0, Q_MAX, Q_MIN);
    load_vec(10'd1023, Q_MIN, Q_MAX);
    load_vec(10'd5, Q_ONE, -Q_ONE);
    load_vec(10'd682, 32'sh1234_5678, 32'sh8765_4321);
    send_entry(Q_MAX, rand_value(), 11'sd0);
    send_entry(Q_MAX, rand_value(), 11'sd0);
    send_entry(Q_MAX, rand_value(), 11'sd0);
    send_entry(Q_MAX, rand_value(), COL_PAD);
    send_entry(Q_MIN, rand_value(), 11'sd0);
    load_vec(10'd1, 32'sh0003_0000, 32'sh0000_8000);
    send_entry(Q_MIN, rand_value(), 11'sd0);
    send_entry(Q_MIN, rand_value(), 11'sd0);
    send_entry(Q_ONE, rand_value(), 11'sh400);
    quiesce();

    // Complex mode with a zero row count, then a row of padding only.
    write_reg(CFG_COMPLEX_MODE, 16'd1);
    write_reg(CFG_ROW_WIDTH, 16'd2);
    write_reg(CFG_ROW_COUNT, 16'd0);
    send_entry(Q_MIN, Q_MIN, 11'sd1023);
    send_entry(Q_ONE, Q_ONE, 11'sd5);
    send_entry(rand_value(), rand_value(), COL_PAD);
    send_entry(rand_value(), rand_value(), -11'sd5);
    quiesce();
    write_reg(CFG_ROW_WIDTH, 16'd0);
    send_entry(Q_ONE, -Q_ONE, 11'sd682);
    quiesce();

    // Leave a row open, then switch to real mode and shrink the width under it.
    write_reg(CFG_ROW_WIDTH, 16'd3);
    send_entry(rand_value(), rand_value(), 11'sd1);
    send_entry(rand_value(), rand_value(), 11'sd682);
    quiesce();
    write_reg(CFG_COMPLEX_MODE, 16'd0);
    write_reg(CFG_ROW_WIDTH, 16'd1);
    send_entry(Q_ONE, Q_ONE, 11'sd5);
    quiesce();

    // Widest row count, then cut it below the running row number.
    write_reg(CFG_ROW_COUNT, 16'hFFFF);
    send_entry(rand_value(), rand_value(), 11'sd0);
    send_entry(rand_value(), rand_value(), 11'sd1023);
    quiesce();
    write_reg(CFG_ROW_COUNT, 16'd1);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    send_entry(rand_value(), rand_value(), 11'sd5);
    send_entry(rand_value(), rand_value(), 11'sd1);

    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      quiesce();
      write_reg(CFG_COMPLEX_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 9))
        0:       width_sel = 7'd64;
        1:       width_sel = 7'd127;
        2:       width_sel = 7'd0;
        default: width_sel = RW_W'($urandom_range(1, 8));
      endcase
      write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(width_sel));
      case ($urandom_range(0, 9))
        0:       count_sel = 16'hFFFF;
        1:       count_sel = 16'd0;
        default: count_sel = ROW_W'($urandom_range(1, 6));
      endcase
      write_reg(CFG_ROW_COUNT, count_sel);
      if ($urandom_range(0, 9) == 0) write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));

      if (width_sel == 0) width_eff = 1;
      else if (width_sel > MAX_ROW_WIDTH_DEF) width_eff = MAX_ROW_WIDTH_DEF;
      else width_eff = width_sel;
      rows = (width_eff > 8) ? 1 : $urandom_range(1, 6);

      repeat ($urandom_range(0, 3)) random_load();
      repeat (rows * width_eff) begin
        if ($urandom_range(0, 99) < 15) random_load();
        random_entry();
      end
      // now and then carry an unfinished row across the next register change
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, width_eff)) random_entry();
    end

    quiesce();
    if (mismatches == 0 && rows_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
